[hdl/skhim_pkg.sv]
// Shared types and constants for the string key hash index map.
// Item structs, command/status structs and table geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skhim_pkg;

  localparam int HASH_BITS   = 32;
  localparam int NUM_BUCKETS = 64;
  localparam int BUCKET_WAYS = 4;
  localparam int MAX_ENTRIES = 1024;

  localparam int CHAR_W     = 8;
  localparam int SLOT_W     = 10;
  localparam int KEY_HASH_W = 32;
  localparam int POS_W      = 16;
  localparam int SQ_W       = 2 * POS_W;
  localparam int BKT_W      = $clog2(NUM_BUCKETS);
  localparam int WAY_W      = $clog2(BUCKET_WAYS);
  localparam int FILL_W     = $clog2(BUCKET_WAYS + 1);
  localparam int IDX_W      = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_AW     = BKT_W + WAY_W;
  localparam int ENT_DEPTH  = NUM_BUCKETS * BUCKET_WAYS;

  localparam logic [POS_W-1:0]  POS_MAX   = '1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUCKET_WAYS);
  localparam logic [IDX_W-1:0]  IDX_LIMIT = IDX_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    ACT_GET    = 1'b0,
    ACT_UPDATE = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] key_char;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot_index;
    logic [KEY_HASH_W-1:0] key_hash;
  } out_item_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [SLOT_W-1:0]    slot;
  } entry_t;

  typedef struct packed {
    logic rd_fill;
    logic way_clr;
    logic rd_entry;
    logic way_inc;
    logic hit;
    logic miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic way_lt_fill;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/skhim_dp.sv]
// Datapath: hash accumulation, bucket fill and entry memories, result
// and output registers. Driven by skhim_ctrl; uses skhim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skhim_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 char_acc,
  input  skhim_pkg::in_item_t in_data,
  input  skhim_pkg::cmd_t     cmd,
  output skhim_pkg::stat_t    stat,
  input  wire                 out_ready,
  output logic                out_valid,
  output skhim_pkg::out_item_t out_data
);
  import skhim_pkg::*;

  logic [HASH_BITS-1:0] run_hash;
  logic [POS_W-1:0]     pos;
  logic [SQ_W-1:0]      sq;
  logic [HASH_BITS-1:0] prod;
  logic [HASH_BITS-1:0] h_new;

  logic [HASH_BITS-1:0] key_hash;
  logic                 act;

  logic [FILL_W-1:0]    fill_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] fill_vld;
  logic [FILL_W-1:0]    fill_rd;
  logic                 fill_ok;
  logic [FILL_W-1:0]    fill_cur;

  entry_t               ent_mem [ENT_DEPTH];
  entry_t               ent_rd;

  logic [FILL_W-1:0]    way;
  logic [IDX_W-1:0]     next_free;
  logic [BKT_W-1:0]     bkt;
  logic                 room;
  logic                 do_ins;

  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;

  // char weight is pos^2 (the first char weighs 1), kept incrementally: (p+1)^2 = p^2 + 2p + 1
  assign prod  = HASH_BITS'(HASH_BITS'(in_data.key_char) * HASH_BITS'(sq));
  assign h_new = (pos == '0) ? HASH_BITS'(in_data.key_char) : run_hash + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_hash <= '0;
      pos      <= '0;
      sq       <= '0;
    end else if (char_acc) begin
      if (in_data.last_char) begin
        run_hash <= '0;
        pos      <= '0;
        sq       <= '0;
      end else begin
        run_hash <= h_new;
        if (pos != POS_MAX) begin
          pos <= pos + 1'b1;
          sq  <= sq + SQ_W'({pos, 1'b1});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_acc && in_data.last_char) begin
      key_hash <= h_new;
      act      <= in_data.action;
    end
  end

  assign bkt      = key_hash[BKT_W-1:0];
  assign fill_cur = fill_ok ? fill_rd : '0;
  assign room     = (fill_cur < FILL_FULL) && (next_free < IDX_LIMIT);
  assign do_ins   = cmd.miss && (act == ACT_UPDATE) && room;

  // bucket fill counts: memory plus per-bucket valid bits cleared at reset
  always_ff @(posedge clk) begin
    if (do_ins) begin
      fill_mem[bkt] <= fill_cur + 1'b1;
    end
    if (cmd.rd_fill) begin
      fill_rd <= fill_mem[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld <= '0;
      fill_ok  <= 1'b0;
    end else begin
      if (do_ins) begin
        fill_vld[bkt] <= 1'b1;
      end
      if (cmd.rd_fill) begin
        fill_ok <= fill_vld[bkt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      ent_mem[{bkt, fill_cur[WAY_W-1:0]}] <= '{hash: key_hash, slot: next_free[SLOT_W-1:0]};
    end
    if (cmd.rd_entry) begin
      ent_rd <= ent_mem[{bkt, way[WAY_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      way       <= '0;
      next_free <= '0;
    end else begin
      if (cmd.way_clr) begin
        way <= '0;
      end else if (cmd.way_inc) begin
        way <= way + 1'b1;
      end
      if (do_ins) begin
        next_free <= next_free + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      res_status <= ST_FOUND;
      res_slot   <= ent_rd.slot;
    end else if (cmd.miss) begin
      if (act == ACT_GET) begin
        res_status <= ST_NOT_FOUND;
        res_slot   <= '0;
      end else if (!room) begin
        res_status <= ST_FULL;
        res_slot   <= '0;
      end else begin
        res_status <= ST_INSERTED;
        res_slot   <= next_free[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= '{status: res_status, slot_index: res_slot,
                    key_hash: key_hash[KEY_HASH_W-1:0]};
    end
  end

  assign stat.match       = (ent_rd.hash == key_hash);
  assign stat.way_lt_fill = (way < fill_cur);
  assign stat.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

[hdl/skhim_ctrl.sv]
// Controller FSM: character accept, bucket fill read, way scan, result
// hand-off. Issues commands to skhim_dp; uses skhim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skhim_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               last_char,
  output logic              in_ready,
  output logic              char_acc,
  input  skhim_pkg::stat_t  stat,
  output skhim_pkg::cmd_t   cmd
);
  import skhim_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_RD   = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);
  assign char_acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (char_acc && last_char) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.rd_fill = 1'b1;
        cmd.way_clr = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        if (stat.way_lt_fill) begin
          cmd.rd_entry = 1'b1;
          state_next   = S_CMP;
        end else begin
          cmd.miss   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.way_inc = 1'b1;
          state_next  = S_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hdl/string_key_hash_index_map.sv]
// String key hash index map: takes key characters one item per cycle
// while in_ready is high, then looks the key up in a 64-bucket, 4-way
// table and answers found, inserted, not found or full. After the last
// character the lookup reads the bucket fill count, then per way reads
// an entry and compares it (one entry memory read port), decides a miss
// when no filled way is left, and loads the output register. Input is
// held off during the lookup; a finished result waits in the output
// register while the next key streams, and a second result holds off
// input until that register frees.
// Depends on skhim_pkg, skhim_ctrl, skhim_dp.
`timescale 1ns / 1ps
`default_nettype none

module string_key_hash_index_map (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  skhim_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output skhim_pkg::out_item_t  out_data
);
  import skhim_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  char_acc;

  skhim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_char (in_data.last_char),
    .in_ready  (in_ready),
    .char_acc  (char_acc),
    .stat      (stat),
    .cmd       (cmd)
  );

  skhim_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_acc  (char_acc),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending item");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL)
      |-> (out_data.slot_index == '0))
    else $error("nonzero slot on miss or full");

  a_lookup_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_char |=> !in_ready)
    else $error("input taken during lookup");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit && cmd.miss))
    else $error("hit and miss together");

endmodule

`default_nettype wire
